// ===== src/fpmm_pkg.sv =====
// Shared types, register codes and helpers of the fixed-point matrix multiply unit.
package fpmm_pkg;

  // Largest matrix dimension and store depth
  localparam int MaxDim     = 8;
  localparam int StoreDepth = MaxDim * MaxDim;
  localparam int DimW       = $clog2(MaxDim);
  localparam int AddrW      = $clog2(StoreDepth);

  // Word widths
  localparam int ElemW  = 16;
  localparam int ProdW  = 2 * ElemW;
  localparam int AccW   = 35;
  localparam int CountW = 8;
  localparam int RegW   = 4;

  // Configuration register indexes (byte address / 4)
  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_LEN = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  localparam logic [RegW-1:0] DIM_RESET = RegW'(MaxDim);

  // Tag that travels with one multiply-accumulate step down the pipeline
  typedef struct packed {
    logic            valid;
    logic            first;
    logic            last;
    logic            final_elem;
    logic [DimW-1:0] row;
    logic [DimW-1:0] col;
  } mac_tag_t;

  // Register value to effective dimension: 0 counts as 1, above MaxDim as MaxDim
  function automatic logic [RegW-1:0] clamp_dim(input logic [RegW-1:0] v);
    logic [RegW-1:0] res;
    res = v;
    if (v == '0) begin
      res = RegW'(1);
    end else if (v > RegW'(MaxDim)) begin
      res = RegW'(MaxDim);
    end
    return res;
  endfunction

endpackage

// ===== src/fixed_point_matrix_multiply_unit.sv =====
// Top level of the fixed-point matrix multiply unit: loader, MAC sequencer, APB registers.
//
//  channel   | signals                                        | handshake
//  ----------+------------------------------------------------+---------------------------
//  input     | element_value                                  | start && !busy
//  result    | product_value, out_row, out_col, last_of_matrix | done, one cycle, no stall
//  config    | psel penable pwrite paddr pwdata prdata pready  | APB write, pready tied high
//
// busy stays low between loading words, so a word is taken whenever start is high.
// The word that completes B starts the shared multiply-accumulate: it issues one MAC a
// cycle over row, column and inner index, then the store read and multiply registers
// drain, with busy high throughout; the final result is on the ports in the cycle after
// the last busy cycle, as busy drops.
// Reset clears the load counter, sequencer and pipeline; the stores are not cleared.
// Results come out one per finished dot product and the receiver cannot stall them.
module fixed_point_matrix_multiply_unit (
  input  logic                                clk,
  input  logic                                rst,
  // input word
  input  logic                                start,
  output logic                                busy,
  input  logic signed [fpmm_pkg::ElemW-1:0]   element_value,
  // result word
  output logic                                done,
  output logic signed [fpmm_pkg::AccW-1:0]    product_value,
  output logic [fpmm_pkg::DimW-1:0]           out_row,
  output logic [fpmm_pkg::DimW-1:0]           out_col,
  output logic                                last_of_matrix,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  // Configuration registers (raw values)
  logic [fpmm_pkg::RegW-1:0] rows_a;
  logic [fpmm_pkg::RegW-1:0] inner_len;
  logic [fpmm_pkg::RegW-1:0] cols_b;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= fpmm_pkg::DIM_RESET;
      inner_len <= fpmm_pkg::DIM_RESET;
      cols_b    <= fpmm_pkg::DIM_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        fpmm_pkg::REG_ROWS_A:    rows_a    <= pwdata[fpmm_pkg::RegW-1:0];
        fpmm_pkg::REG_INNER_LEN: inner_len <= pwdata[fpmm_pkg::RegW-1:0];
        fpmm_pkg::REG_COLS_B:    cols_b    <= pwdata[fpmm_pkg::RegW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (paddr[3:2])
      fpmm_pkg::REG_ROWS_A:    prdata = 32'(rows_a);
      fpmm_pkg::REG_INNER_LEN: prdata = 32'(inner_len);
      fpmm_pkg::REG_COLS_B:    prdata = 32'(cols_b);
      default:                 prdata = '0;
    endcase
  end

  // Effective dimensions
  logic [fpmm_pkg::RegW-1:0] ra;
  logic [fpmm_pkg::RegW-1:0] kk;
  logic [fpmm_pkg::RegW-1:0] cb;
  logic [fpmm_pkg::DimW-1:0] ra_m1;
  logic [fpmm_pkg::DimW-1:0] kk_m1;
  logic [fpmm_pkg::DimW-1:0] cb_m1;
  logic [6:0]                na;
  logic [7:0]                total;

  assign ra    = fpmm_pkg::clamp_dim(rows_a);
  assign kk    = fpmm_pkg::clamp_dim(inner_len);
  assign cb    = fpmm_pkg::clamp_dim(cols_b);
  assign ra_m1 = fpmm_pkg::DimW'(ra - 4'd1);
  assign kk_m1 = fpmm_pkg::DimW'(kk - 4'd1);
  assign cb_m1 = fpmm_pkg::DimW'(cb - 4'd1);
  assign na    = 7'(ra) * 7'(kk);
  assign total = 8'(na) + 8'(7'(kk) * 7'(cb));

  // Loader: load counter and store writes
  logic [fpmm_pkg::CountW-1:0] load_count;
  logic                        accept;
  logic [8:0]                  idx_inc;
  logic                        completes;
  logic [7:0]                  b_off;
  logic                        a_we;
  logic                        b_we;
  logic                        running;

  assign accept    = start && !busy;
  assign idx_inc   = 9'(load_count) + 9'd1;
  assign completes = !(idx_inc < 9'(total));
  assign b_off     = load_count - 8'(na);
  assign a_we      = accept && (load_count < 8'(na));
  assign b_we      = accept && !(load_count < 8'(na)) && (b_off < 8'(fpmm_pkg::StoreDepth));

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (accept) begin
      load_count <= completes ? '0 : idx_inc[fpmm_pkg::CountW-1:0];
    end
  end

  // Operand stores
  logic [fpmm_pkg::ElemW-1:0] a_mem [fpmm_pkg::StoreDepth];
  logic [fpmm_pkg::ElemW-1:0] b_mem [fpmm_pkg::StoreDepth];
  logic [fpmm_pkg::ElemW-1:0] a_rd;
  logic [fpmm_pkg::ElemW-1:0] b_rd;
  logic [fpmm_pkg::AddrW-1:0] a_raddr;
  logic [fpmm_pkg::AddrW-1:0] b_raddr;

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[load_count[fpmm_pkg::AddrW-1:0]] <= element_value;
    end
    a_rd <= a_mem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[b_off[fpmm_pkg::AddrW-1:0]] <= element_value;
    end
    b_rd <= b_mem[b_raddr];
  end

  // Sequencer over row, column and inner index
  logic [fpmm_pkg::DimW-1:0] r_idx;
  logic [fpmm_pkg::DimW-1:0] c_idx;
  logic [fpmm_pkg::DimW-1:0] k_idx;
  logic                      k_end;
  logic                      c_end;
  logic                      r_end;

  assign k_end   = (k_idx == kk_m1);
  assign c_end   = (c_idx == cb_m1);
  assign r_end   = (r_idx == ra_m1);
  assign a_raddr = fpmm_pkg::AddrW'(6'(r_idx) * 6'(kk) + 6'(k_idx));
  assign b_raddr = fpmm_pkg::AddrW'(6'(k_idx) * 6'(cb) + 6'(c_idx));

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      r_idx   <= '0;
      c_idx   <= '0;
      k_idx   <= '0;
    end else if (!running) begin
      if (accept && completes) begin
        running <= 1'b1;
        r_idx   <= '0;
        c_idx   <= '0;
        k_idx   <= '0;
      end
    end else if (!k_end) begin
      k_idx <= k_idx + fpmm_pkg::DimW'(1);
    end else begin
      k_idx <= '0;
      if (!c_end) begin
        c_idx <= c_idx + fpmm_pkg::DimW'(1);
      end else begin
        c_idx <= '0;
        if (r_end) begin
          running <= 1'b0;
        end else begin
          r_idx <= r_idx + fpmm_pkg::DimW'(1);
        end
      end
    end
  end

  // MAC pipeline: store read, multiply, accumulate
  fpmm_pkg::mac_tag_t              issue_tag;
  fpmm_pkg::mac_tag_t              s1;
  fpmm_pkg::mac_tag_t              s2;
  logic signed [fpmm_pkg::ProdW-1:0] prod;
  logic signed [fpmm_pkg::AccW-1:0]  acc;
  logic signed [fpmm_pkg::AccW-1:0]  acc_next;

  always_comb begin
    issue_tag.valid      = running;
    issue_tag.first      = (k_idx == '0);
    issue_tag.last       = k_end;
    issue_tag.final_elem = r_end && c_end;
    issue_tag.row        = r_idx;
    issue_tag.col        = c_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
    end else begin
      s1 <= issue_tag;
      s2 <= s1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed(a_rd) * $signed(b_rd);
  end

  assign acc_next = (s2.first ? '0 : acc) + fpmm_pkg::AccW'(prod);

  always_ff @(posedge clk) begin
    if (s2.valid) begin
      acc <= acc_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2.valid && s2.last;
    end
  end

  always_ff @(posedge clk) begin
    if (s2.valid && s2.last) begin
      product_value  <= acc_next;
      out_row        <= s2.row;
      out_col        <= s2.col;
      last_of_matrix <= s2.final_elem;
    end
  end

  assign busy = running || s1.valid || s2.valid;

`ifndef SYNTHESIS
  // Computation starts only on the word that completes B, which rewinds the counter
  a_start_rewinds: assert property (@(posedge clk) disable iff (rst)
    $rose(running) |-> (load_count == '0))
    else $error("compute started without rewinding the load counter");

  // The end of a dot product always yields a result on the next cycle
  a_dot_result: assert property (@(posedge clk) disable iff (rst)
    (s2.valid && s2.last) |=> done)
    else $error("finished dot product gave no result");

  // Nothing follows the final result of a product until a new pair is loaded
  a_final_alone: assert property (@(posedge clk) disable iff (rst)
    (done && last_of_matrix) |=> !done)
    else $error("result emitted after the final element");

  // No new word is taken while the MAC pipeline is active
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (running || s1.valid) |-> !accept)
    else $error("word accepted during computation");
`endif

endmodule

// ===== bench/fixed_point_matrix_multiply_unit_tb.sv =====
// Self-checking bench for the fixed-point matrix multiply unit: directed and random loads.
`timescale 1ns / 1ps

module fixed_point_matrix_multiply_unit_tb;

  localparam int SettleCycles = 520;   // worst-case MAC run of an 8x8 pair plus margin
  localparam int QuietLimit   = 4000;  // cycles with no traffic before giving up
  localparam int RandomWords  = 310;

  typedef struct {
    logic signed [fpmm_pkg::AccW-1:0] value;
    logic [fpmm_pkg::DimW-1:0]        row;
    logic [fpmm_pkg::DimW-1:0]        col;
    logic                             last;
  } product_word_t;

  typedef enum int {FILL_FULL_RANGE, FILL_EXTREMES, FILL_SMALL} fill_mode_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              start = 1'b0;
  logic                              busy;
  logic signed [fpmm_pkg::ElemW-1:0] element_value = '0;
  logic                              done;
  logic signed [fpmm_pkg::AccW-1:0]  product_value;
  logic [fpmm_pkg::DimW-1:0]         out_row;
  logic [fpmm_pkg::DimW-1:0]         out_col;
  logic                              last_of_matrix;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [3:0]                        paddr = '0;
  logic [31:0]                       pwdata = '0;
  logic [31:0]                       prdata;
  logic                              pready;

  fixed_point_matrix_multiply_unit uut (
    .clk, .rst, .start, .busy, .element_value,
    .done, .product_value, .out_row, .out_col, .last_of_matrix,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Bench copy of the block state
  logic [fpmm_pkg::RegW-1:0]         dim_rows = fpmm_pkg::DIM_RESET;
  logic [fpmm_pkg::RegW-1:0]         dim_inner = fpmm_pkg::DIM_RESET;
  logic [fpmm_pkg::RegW-1:0]         dim_cols = fpmm_pkg::DIM_RESET;
  logic signed [fpmm_pkg::ElemW-1:0] a_mem [fpmm_pkg::StoreDepth];
  logic signed [fpmm_pkg::ElemW-1:0] b_mem [fpmm_pkg::StoreDepth];
  int                                load_count = 0;

  logic signed [fpmm_pkg::ElemW-1:0] queued_elements [$];
  product_word_t                     pending_products [$];
  int                                words_sent = 0;
  int                                words_taken = 0;
  int                                gap_pct = 0;
  int                                mismatch_count = 0;
  int                                quiet_cycles = 0;

  // Register value to the dimension actually used
  function automatic int eff_dim(input logic [fpmm_pkg::RegW-1:0] raw);
    if (raw == '0) return 1;
    if (int'(raw) > fpmm_pkg::MaxDim) return fpmm_pkg::MaxDim;
    return int'(raw);
  endfunction

  // Store one element; on the word that completes B, queue the whole product
  task automatic load_element(input logic signed [fpmm_pkg::ElemW-1:0] value);
    int            ra, kk, cb, na, total, idx;
    longint        acc;
    product_word_t word;
    ra    = eff_dim(dim_rows);
    kk    = eff_dim(dim_inner);
    cb    = eff_dim(dim_cols);
    na    = ra * kk;
    total = na + kk * cb;
    idx   = load_count;
    if (idx < na) begin
      a_mem[idx % fpmm_pkg::StoreDepth] = value;
    end else if (idx - na < fpmm_pkg::StoreDepth) begin
      b_mem[idx - na] = value;
    end
    if (idx + 1 < total) begin
      load_count = (idx + 1) & 255;
    end else begin
      load_count = 0;
      for (int r = 0; r < ra; r++) begin
        for (int c = 0; c < cb; c++) begin
          acc = 0;
          for (int k = 0; k < kk; k++) begin
            acc += longint'(a_mem[(r * kk + k) % fpmm_pkg::StoreDepth]) *
                   longint'(b_mem[(k * cb + c) % fpmm_pkg::StoreDepth]);
          end
          word.value = acc[fpmm_pkg::AccW-1:0];
          word.row   = fpmm_pkg::DimW'(r);
          word.col   = fpmm_pkg::DimW'(c);
          word.last  = (r + 1 == ra) && (c + 1 == cb);
          pending_products.push_back(word);
        end
      end
    end
  endtask

  // Driver: next element goes out at the falling edge once the last one was taken
  always @(negedge clk) begin
    if (!rst && words_taken == words_sent) begin
      if (queued_elements.size() > 0 && $urandom_range(99) >= gap_pct) begin
        start         <= 1'b1;
        element_value <= queued_elements.pop_front();
        words_sent++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: capture accepted words, register writes and results at the rising edge
  always @(posedge clk) begin
    product_word_t want;
    bit            quiet;
    quiet = 1'b1;
    if (!rst) begin
      if (psel && penable && pwrite && pready) begin
        quiet = 1'b0;
        case (paddr[3:2])
          fpmm_pkg::REG_ROWS_A:    dim_rows  = pwdata[fpmm_pkg::RegW-1:0];
          fpmm_pkg::REG_INNER_LEN: dim_inner = pwdata[fpmm_pkg::RegW-1:0];
          fpmm_pkg::REG_COLS_B:    dim_cols  = pwdata[fpmm_pkg::RegW-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        quiet = 1'b0;
        load_element(element_value);
        words_taken++;
      end
      if (done) begin
        quiet = 1'b0;
        if (pending_products.size() == 0) begin
          $error("unexpected result word at row %0d col %0d", out_row, out_col);
          mismatch_count++;
        end else begin
          want = pending_products.pop_front();
          if (product_value !== want.value) begin
            $error("product_value: expected %0d, got %0d", want.value, product_value);
            mismatch_count++;
          end
          if (out_row !== want.row) begin
            $error("out_row: expected %0d, got %0d", want.row, out_row);
            mismatch_count++;
          end
          if (out_col !== want.col) begin
            $error("out_col: expected %0d, got %0d", want.col, out_col);
            mismatch_count++;
          end
          if (last_of_matrix !== want.last) begin
            $error("last_of_matrix: expected %0d, got %0d", want.last, last_of_matrix);
            mismatch_count++;
          end
        end
      end
    end
    quiet_cycles = quiet ? quiet_cycles + 1 : 0;
    if (quiet_cycles >= QuietLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // APB write: setup cycle then access cycle; upper data bits are don't-care
  task automatic write_reg(input logic [1:0] index,
                           input logic [fpmm_pkg::RegW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= ($urandom() & 32'hFFFF_FFF0) | 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_dims(input logic [fpmm_pkg::RegW-1:0] rows,
                            input logic [fpmm_pkg::RegW-1:0] inner,
                            input logic [fpmm_pkg::RegW-1:0] cols);
    write_reg(fpmm_pkg::REG_ROWS_A, rows);
    write_reg(fpmm_pkg::REG_INNER_LEN, inner);
    write_reg(fpmm_pkg::REG_COLS_B, cols);
  endtask

  // Wait for every word to be taken and every product word to arrive, then settle
  task automatic settle();
    while (queued_elements.size() > 0 || words_taken != words_sent ||
           pending_products.size() > 0) begin
      @(posedge clk);
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic logic signed [fpmm_pkg::ElemW-1:0] make_element(input fill_mode_t mode);
    logic signed [fpmm_pkg::ElemW-1:0] corners [5];
    corners = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1, 16'sd1};
    case (mode)
      FILL_EXTREMES: return corners[$urandom_range(4)];
      FILL_SMALL:    return fpmm_pkg::ElemW'($urandom_range(511)) - 16'sd256;
      default:       return fpmm_pkg::ElemW'($urandom_range(65535));
    endcase
  endfunction

  task automatic push_elements(input int count, input fill_mode_t mode);
    repeat (count) queued_elements.push_back(make_element(mode));
  endtask

  // Mostly small dimensions, sometimes the largest or out-of-range values
  function automatic logic [fpmm_pkg::RegW-1:0] pick_dim();
    case ($urandom_range(9))
      0:       return '0;
      1:       return fpmm_pkg::RegW'($urandom_range(15, fpmm_pkg::MaxDim + 1));
      2:       return fpmm_pkg::RegW'(fpmm_pkg::MaxDim);
      default: return fpmm_pkg::RegW'($urandom_range(4, 1));
    endcase
  endfunction

  initial begin
    int                        gap_levels [4];
    int                        random_count, phase, carry, total, pairs;
    logic [fpmm_pkg::RegW-1:0] rows, inner, cols;
    fill_mode_t                mode;
    gap_levels   = '{0, 73, 0, 29};
    random_count = 0;
    phase        = 0;
    carry        = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero dimensions count as one, corner products of single elements
    write_dims('0, '0, '0);
    queued_elements.push_back(16'sh8000);
    queued_elements.push_back(16'sh8000);
    queued_elements.push_back(16'sh7FFF);
    queued_elements.push_back(16'sh8000);
    queued_elements.push_back(16'sh7FFF);
    queued_elements.push_back(16'sh7FFF);
    queued_elements.push_back(-16'sd1);
    queued_elements.push_back(16'sd1);
    settle();
    // Oversized inner length clamps to eight: largest possible dot product
    write_dims('0, 4'd15, '0);
    repeat (16) queued_elements.push_back(16'sh8000);
    settle();

    // Random phases; the first fills both stores completely with an 8x8 pair
    while (random_count < RandomWords) begin
      gap_pct = gap_levels[phase % 4];
      if (phase == 0) begin
        rows  = fpmm_pkg::RegW'(fpmm_pkg::MaxDim);
        inner = fpmm_pkg::RegW'(fpmm_pkg::MaxDim);
        cols  = fpmm_pkg::RegW'(fpmm_pkg::MaxDim);
      end else begin
        rows  = pick_dim();
        inner = pick_dim();
        cols  = pick_dim();
      end
      write_dims(rows, inner, cols);
      total = eff_dim(rows) * eff_dim(inner) + eff_dim(inner) * eff_dim(cols);
      // Finish a load left open by the previous phase under the new sizes
      if (carry > 0) begin
        push_elements((carry >= total) ? 1 : total - carry, FILL_FULL_RANGE);
        random_count += (carry >= total) ? 1 : total - carry;
        carry = 0;
      end
      pairs = (phase == 0) ? 1 : $urandom_range(3, 1);
      repeat (pairs) begin
        case ($urandom_range(9))
          0:       mode = FILL_EXTREMES;
          1:       mode = FILL_SMALL;
          default: mode = FILL_FULL_RANGE;
        endcase
        push_elements(total, mode);
        random_count += total;
      end
      // Now and then leave a pair partly loaded so the next sizes apply mid-load
      if (total > 1 && $urandom_range(3) == 0) begin
        carry = $urandom_range(total - 1, 1);
        push_elements(carry, FILL_FULL_RANGE);
        random_count += carry;
      end
      settle();
      phase++;
    end

    if (mismatch_count == 0 && pending_products.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
